/* design/aas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_pkg
// shared widths, register codes and saturation helpers of the auction solver
// ----------------------------------------------------------------------------
package aas_pkg;

  localparam int IDX_W       = 4;
  localparam int SIZE_W      = 5;
  localparam int PRICE_W     = 48;
  localparam int VAL_W       = 64;
  localparam int WIDE_W      = 66;
  localparam int RESULT_CAP  = 16;
  localparam int RND_W       = 21;
  localparam int ROUND_LIMIT = 1048576;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // register index codes
  localparam logic REG_SIZE_IN_USE = 1'b0;

  localparam logic signed [WIDE_W-1:0] VAL_LIM   = 66'sd1 <<< 61;
  localparam logic signed [WIDE_W-1:0] PRICE_MAX = (66'sd1 <<< 47) - 66'sd1;
  localparam logic signed [WIDE_W-1:0] PRICE_MIN = -(66'sd1 <<< 47);

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] y;
    y = x;
    if (x > VAL_LIM) y = VAL_LIM;
    else if (x < -VAL_LIM) y = -VAL_LIM;
    return VAL_W'(y);
  endfunction

  function automatic logic signed [PRICE_W-1:0] sat_price(
      input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] y;
    y = x;
    if (x > PRICE_MAX) y = PRICE_MAX;
    else if (x < PRICE_MIN) y = PRICE_MIN;
    return PRICE_W'(y);
  endfunction

endpackage

/* design/aas_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module aas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/auction_assignment_solver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auction_assignment_solver_core
// n-by-n assignment solver: jacobi auction with epsilon scaling, q.24 prices
// ----------------------------------------------------------------------------
// usage
//   input channel: one benefit entry (row, column, benefit) per item, taken
//   at a clock edge with start high and busy low. entries without
//   last_entry load at one item per cycle. an item with last_entry stores
//   its entry and starts the solve; busy stays high until the last result.
//   results: one item per person 0..n-1, each shown for one cycle with
//   strobe high; the receiver cannot stall, so no back-pressure exists.
//   config: apb port, size_in_use at address 0; the user writes it only while idle, the block does not check.
// sequence
//   each round scans every free person over n benefit reads through the
//   registered benefit ram read, skipping persons that already hold an
//   object, then every object over n bidders, plus round overhead. each
//   phase adds a divide by 20 step and an epsilon test step. after the
//   auction, a fill pass and a result pass follow, results back to back.
//   size one skips the auction and goes straight to the result state.
// reset
//   synchronous rst returns to idle and sets size_in_use to 16; the
//   benefit matrix is not cleared and must be loaded before a solve.
// ----------------------------------------------------------------------------
module auction_assignment_solver_core
  import aas_pkg::*;
#(
  parameter int MAX_PERSONS     = 16,
  parameter int BENEFIT_WIDTH   = 16,
  parameter int PRICE_FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  // item input
  input  logic                            start,
  output logic                            busy,
  input  logic [IDX_W-1:0]                row,
  input  logic [IDX_W-1:0]                column,
  input  logic signed [BENEFIT_WIDTH-1:0] benefit,
  input  logic                            last_entry,
  // result output
  output logic                            strobe,
  output logic [IDX_W-1:0]                person,
  output logic [IDX_W-1:0]                object,
  output logic signed [PRICE_W-1:0]       object_price,
  output logic                            last_result,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ADDR_W-1:0]               paddr,
  input  logic [DATA_W-1:0]               pwdata,
  output logic [DATA_W-1:0]               prdata,
  output logic                            pready
);

  localparam int PW   = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;
  localparam int CW   = PW + 1;
  localparam int AW   = $clog2(MAX_PERSONS * MAX_PERSONS);
  localparam int EW   = PRICE_FRAC_BITS + 1;
  localparam int NCAP = (MAX_PERSONS < RESULT_CAP) ? MAX_PERSONS : RESULT_CAP;

  typedef enum logic [3:0] {
    S_IDLE, S_EPS_CHECK, S_BID_NEXT, S_BID_SCAN, S_BID_WRITE, S_AW_SCAN,
    S_AW_APPLY, S_ROUND_END, S_EPS_DIV, S_FILL, S_OUT
  } state_t;

  state_t state;

  // configuration register
  logic [SIZE_W-1:0] size_in_use;

  // auction state
  logic signed [PRICE_W-1:0] price_tab  [MAX_PERSONS];
  logic [PW-1:0]             owner      [MAX_PERSONS];
  logic [MAX_PERSONS-1:0]    owner_vld;
  logic [PW-1:0]             bid_target [MAX_PERSONS];
  logic signed [VAL_W-1:0]   bid_amount [MAX_PERSONS];
  logic [MAX_PERSONS-1:0]    bidding;
  logic [EW-1:0]             eps;

  // sequencer counters
  logic [CW-1:0]    n_used;
  logic [CW-1:0]    p_cnt;
  logic [CW-1:0]    j_cnt;
  logic [CW-1:0]    iss_j;
  logic             arr_vld;
  logic [PW-1:0]    arr_j;
  logic [RND_W-1:0] rounds;

  // best and second search
  logic signed [VAL_W-1:0] best;
  logic signed [VAL_W-1:0] second;
  logic                    have_best;
  logic                    have_second;
  logic [PW-1:0]           best_j;

  // object award search
  logic                    found;
  logic [PW-1:0]           win;
  logic signed [VAL_W-1:0] win_amt;

  // benefit ram
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [AW-1:0]                   ram_raddr;
  logic signed [BENEFIT_WIDTH-1:0] ram_rdata;

  logic          in_acc;
  logic [PW-1:0] pp;
  logic [PW-1:0] pr_idx;
  logic signed [PRICE_W-1:0] pr_data;
  logic signed [VAL_W-1:0]   val;
  logic signed [VAL_W-1:0]   bid_next;
  logic signed [PRICE_W-1:0] price_next;
  logic [MAX_PERSONS-1:0]    held;
  logic [PW-1:0]             free_j;
  logic                      free_found;
  logic                      all_assigned;
  logic [EW+CW-1:0]          eps_prod;
  logic [EW+CW-1:0]          one_wide;
  logic [31:0]               eps_q4;
  logic [63:0]               eps_mul;
  logic [EW-1:0]             eps_div;
  logic [CW-1:0]             n_clamped;
  logic [EW-1:0]             eps_one;

  assign in_acc = start && !busy;
  assign busy   = (state != S_IDLE) || strobe;
  assign pp     = p_cnt[PW-1:0];
  assign pready = 1'b1;
  assign eps_one = EW'(1) << PRICE_FRAC_BITS;

  // apb register access, register index taken from the word address
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SIZE_IN_USE) begin
        size_in_use <= pwdata[SIZE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? DATA_W'(size_in_use) : '0;

  // clamp the problem size to 1..cap
  always_comb begin
    if (size_in_use == '0) n_clamped = CW'(1);
    else if (int'(size_in_use) > NCAP) n_clamped = CW'(NCAP);
    else n_clamped = CW'(size_in_use);
  end

  // benefit entries land in the ram as they arrive, out-of-range ones dropped
  assign ram_we    = in_acc && (int'(row) < MAX_PERSONS) && (int'(column) < MAX_PERSONS);
  assign ram_waddr = AW'(int'(row) * MAX_PERSONS + int'(column));
  assign ram_raddr = AW'(int'(pp) * MAX_PERSONS + int'(iss_j[PW-1:0]));

  aas_ram #(
    .WIDTH (BENEFIT_WIDTH),
    .DEPTH (MAX_PERSONS * MAX_PERSONS)
  ) u_benefit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (benefit),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // single price read port, address chosen by the sequencer step
  always_comb begin
    unique case (state)
      S_BID_SCAN: pr_idx = arr_j;
      S_OUT:      pr_idx = owner[pp];
      default:    pr_idx = j_cnt[PW-1:0];
    endcase
  end
  assign pr_data = price_tab[pr_idx];

  // value of the arriving object: benefit scaled, minus price, saturated
  always_comb begin
    logic signed [WIDE_W-1:0] bs;
    bs  = WIDE_W'(ram_rdata) <<< PRICE_FRAC_BITS;
    val = sat_val(WIDE_W'(sat_val(bs)) - WIDE_W'(pr_data));
  end

  // bid = best - second + epsilon
  assign bid_next = VAL_W'(WIDE_W'(best) - WIDE_W'(second) + WIDE_W'(eps));

  // winning bid raises the price, saturated to 48 bits
  assign price_next = sat_price(WIDE_W'(pr_data) + WIDE_W'(win_amt));

  // objects currently held, and the lowest free one
  always_comb begin
    held = '0;
    for (int q = 0; q < MAX_PERSONS; q++) begin
      if (owner_vld[q] && (int'(owner[q]) < MAX_PERSONS)) held[owner[q]] = 1'b1;
    end
    free_j     = '0;
    free_found = 1'b0;
    for (int q = MAX_PERSONS - 1; q >= 0; q--) begin
      if (!held[q] && (q < int'(n_used))) begin
        free_j     = PW'(q);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    all_assigned = 1'b1;
    for (int q = 0; q < MAX_PERSONS; q++) begin
      if ((q < int'(n_used)) && !owner_vld[q]) all_assigned = 1'b0;
    end
  end

  // phase test eps > 1/n done exactly as eps * n > 2^frac
  assign eps_prod  = (EW+CW)'(eps) * (EW+CW)'(n_used);
  assign one_wide  = (EW+CW)'(1) << PRICE_FRAC_BITS;

  // eps / 20 as (eps / 4) / 5, the divide by 5 by reciprocal multiply
  assign eps_q4  = 32'(eps >> 2);
  assign eps_mul = 64'(eps_q4) * 64'(32'hCCCCCCCD);
  assign eps_div = EW'(eps_mul >> 34);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      strobe      <= 1'b0;
      owner_vld   <= '0;
      bidding     <= '0;
      p_cnt       <= '0;
      j_cnt       <= '0;
      iss_j       <= '0;
      arr_vld     <= 1'b0;
      rounds      <= '0;
      found       <= 1'b0;
      have_best   <= 1'b0;
      have_second <= 1'b0;
      n_used      <= CW'(1);
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc && last_entry) begin
            for (int q = 0; q < MAX_PERSONS; q++) begin
              price_tab[q] <= PRICE_W'(eps_one);
              owner[q]     <= '0;
            end
            eps       <= eps_one;
            n_used    <= n_clamped;
            p_cnt     <= '0;
            owner_vld <= '0;
            if (n_clamped == CW'(1)) begin
              owner_vld[0] <= 1'b1;
              state        <= S_OUT;
            end else begin
              state <= S_EPS_CHECK;
            end
          end
        end

        S_EPS_CHECK: begin
          p_cnt <= '0;
          if (eps_prod > one_wide) begin
            owner_vld <= '0;
            bidding   <= '1;
            rounds    <= '0;
            state     <= S_BID_NEXT;
          end else begin
            state <= S_FILL;
          end
        end

        S_BID_NEXT: begin
          if (p_cnt == n_used) begin
            p_cnt <= '0;
            j_cnt <= '0;
            found <= 1'b0;
            state <= S_AW_SCAN;
          end else if (bidding[pp]) begin
            iss_j       <= '0;
            arr_vld     <= 1'b0;
            have_best   <= 1'b0;
            have_second <= 1'b0;
            state       <= S_BID_SCAN;
          end else begin
            p_cnt <= p_cnt + CW'(1);
          end
        end

        S_BID_SCAN: begin
          // issue one benefit read a cycle, consume the one issued before
          arr_vld <= (iss_j < n_used);
          arr_j   <= iss_j[PW-1:0];
          if (iss_j < n_used) iss_j <= iss_j + CW'(1);
          if (arr_vld) begin
            if (!have_best || (val > best)) begin
              if (have_best) begin
                second      <= best;
                have_second <= 1'b1;
              end
              best      <= val;
              best_j    <= arr_j;
              have_best <= 1'b1;
            end else if (!have_second || (val > second)) begin
              second      <= val;
              have_second <= 1'b1;
            end
            if (CW'(arr_j) == n_used - CW'(1)) begin
              arr_vld <= 1'b0;
              state   <= S_BID_WRITE;
            end
          end
        end

        S_BID_WRITE: begin
          bid_target[pp] <= best_j;
          bid_amount[pp] <= bid_next;
          p_cnt          <= p_cnt + CW'(1);
          state          <= S_BID_NEXT;
        end

        S_AW_SCAN: begin
          // highest bid wins, strict compare keeps the lowest person on ties
          if (bidding[pp] && (bid_target[pp] == j_cnt[PW-1:0]) &&
              (!found || (bid_amount[pp] > win_amt))) begin
            found   <= 1'b1;
            win     <= pp;
            win_amt <= bid_amount[pp];
          end
          if (p_cnt == n_used - CW'(1)) begin
            state <= S_AW_APPLY;
          end else begin
            p_cnt <= p_cnt + CW'(1);
          end
        end

        S_AW_APPLY: begin
          if (found) begin
            for (int q = 0; q < MAX_PERSONS; q++) begin
              if (owner_vld[q] && (owner[q] == j_cnt[PW-1:0])) owner_vld[q] <= 1'b0;
            end
            owner[win]             <= j_cnt[PW-1:0];
            owner_vld[win]         <= 1'b1;
            price_tab[j_cnt[PW-1:0]] <= price_next;
          end
          p_cnt <= '0;
          found <= 1'b0;
          if (j_cnt == n_used - CW'(1)) begin
            state <= S_ROUND_END;
          end else begin
            j_cnt <= j_cnt + CW'(1);
            state <= S_AW_SCAN;
          end
        end

        S_ROUND_END: begin
          p_cnt <= '0;
          if (all_assigned) begin
            state <= S_EPS_DIV;
          end else if (rounds == RND_W'(ROUND_LIMIT - 1)) begin
            state <= S_FILL;
          end else begin
            rounds  <= rounds + RND_W'(1);
            bidding <= ~owner_vld;
            state   <= S_BID_NEXT;
          end
        end

        S_EPS_DIV: begin
          // scale epsilon by 0.05, rounded down
          eps   <= eps_div;
          state <= S_EPS_CHECK;
        end

        S_FILL: begin
          // free persons take the lowest object nobody holds
          if (!owner_vld[pp]) begin
            owner[pp]     <= free_found ? free_j : '0;
            owner_vld[pp] <= 1'b1;
          end
          if (p_cnt == n_used - CW'(1)) begin
            p_cnt <= '0;
            state <= S_OUT;
          end else begin
            p_cnt <= p_cnt + CW'(1);
          end
        end

        S_OUT: begin
          strobe       <= 1'b1;
          person       <= IDX_W'(pp);
          object       <= IDX_W'(owner[pp]);
          object_price <= pr_data;
          last_result  <= (p_cnt == n_used - CW'(1));
          if (p_cnt == n_used - CW'(1)) begin
            state <= S_IDLE;
          end else begin
            p_cnt <= p_cnt + CW'(1);
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/aas_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_checker
// port-level checks of the auction solver result sequence
// ----------------------------------------------------------------------------
module aas_checker
  import aas_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             last_entry,
  input logic             strobe,
  input logic [IDX_W-1:0] person,
  input logic             last_result
);

  // a solve start makes the block busy
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_entry |=> busy)
    else $error("solve start did not raise busy");

  // results only while busy
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result item outside a solve");

  // result sequence opens at person 0
  a_first_person: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> person == '0)
    else $error("first result item not person 0");

  // results continue back to back with rising person until the last
  a_person_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_result |=> strobe && (person == IDX_W'($past(person) + 1'b1)))
    else $error("result items not contiguous");

endmodule

bind auction_assignment_solver_core aas_checker u_aas_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .last_entry  (last_entry),
  .strobe      (strobe),
  .person      (person),
  .last_result (last_result)
);
